### rtl/wrld_pkg.sv
// Package for the word run-length decoder: phase and status codes,
// result record, capacity constants. No dependencies.
package wrld_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned CapW    = 22;
  localparam int unsigned OffW    = 21;
  localparam int unsigned CntW    = 15;
  localparam int unsigned StatW   = 2;
  localparam int unsigned DataW   = 56;  // status + offset + value + count, padded to bytes
  localparam int unsigned AddrW   = 3;

  localparam logic [CapW-1:0]  MaxCapacity = 22'd2097152;
  localparam logic [WordW-1:0] EndMarker   = 16'hFFFF;
  localparam logic [WordW-1:0] VersionZero = 16'h0000;
  localparam logic [AddrW-1:0] CapAddr     = 3'd0;

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_DESC    = 3'd1,
    PH_RUNVAL  = 3'd2,
    PH_LITERAL = 3'd3,
    PH_DISCARD = 3'd4
  } phase_t;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SMALL = 2'd1,
    ST_CORRUPT   = 2'd2
  } status_t;

  typedef struct packed {
    logic            kind;
    status_t         status;
    logic [OffW-1:0] write_offset;
    logic [WordW-1:0] write_value;
    logic [CntW-1:0] repeat_count;
  } result_t;

  typedef struct packed {
    phase_t          phase;
    logic [CapW-1:0] write_position;
  } dec_status_t;

endpackage

### rtl/word_rle_decoder_core.sv
// Top level of the word run-length decoder: configuration port, decoder
// state machine and result buffer. Depends on wrld_pkg and its submodules.
//
// One compressed 16-bit word enters per in_ transfer, with in_tlast marking
// the last available word. A stream is a zero version word, then run and
// literal descriptors, closed by 0xFFFF. Each word yields at most one
// result on the out_ channel: a write command (out_tuser low) or a stream
// status (out_tuser high; 0 ok, 1 destination too small, 2 corrupt).
// Each result is registered in the result buffer (or its skid entry) before it
// is presented. Throughput is one word per cycle while in_tready is high,
// set by the state update in the decoder.
// When the receiver stalls, one more result goes into a skid entry; in_tready
// drops only while that entry is full.
// Reset (rst_n low, synchronous) empties the buffer, sets the decoder to
// expect a version word and the capacity register to 2097152 words.
// capacity_words lies at address 0; the user must write it only while idle, as the block does not enforce this.
module word_rle_decoder_core import wrld_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [WordW-1:0] in_tdata,   // [15:0] stream_word
  input  logic             in_tlast,   // end_of_stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [DataW-1:0] out_tdata,  // [1:0] status, [22:2] write_offset,
                                       // [38:23] write_value, [53:39] repeat_count
  output logic             out_tuser,  // [0] kind
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic            accept;
  logic [CapW-1:0] capacity;
  logic            res_valid;
  result_t         res;
  dec_status_t     dstat;
  logic            can_push;
  result_t         out_res;
  logic            skid_full;

  wrld_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .capacity (capacity)
  );

  assign in_tready = can_push;
  assign accept    = in_tvalid && can_push;

  wrld_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .word      (in_tdata),
    .eos       (in_tlast),
    .capacity  (capacity),
    .res_valid (res_valid),
    .res       (res),
    .dstat     (dstat)
  );

  wrld_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res),
    .skid_full (skid_full)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {2'b00, out_res.repeat_count, out_res.write_value,
                      out_res.write_offset, out_res.status};

  // The skid entry only fills behind a stalled result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> out_tvalid)
    else $error("skid entry holds a result while the output register is empty");

  // The last word of a discarded stream rearms the version check.
  a_discard_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast && dstat.phase == PH_DISCARD) |=> dstat.phase == PH_VERSION)
    else $error("discard did not end on the last word");

  // Writes never run past the largest destination.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.write_position <= MaxCapacity)
    else $error("write position beyond maximum capacity");

  // A status result always resets the decoder out of the literal and run phases.
  a_status_exits: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind) |=> (dstat.phase == PH_VERSION || dstat.phase == PH_DISCARD))
    else $error("status result left the decoder inside a stream");

endmodule

### rtl/wrld_cfg.sv
// Configuration register file: APB-style access to capacity_words.
// Depends on wrld_pkg.
module wrld_cfg import wrld_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CapW-1:0]  capacity
);

  logic [CapW-1:0] cap_r;
  logic [CapW-1:0] cap_nxt;

  assign pready = 1'b1;

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && pready && (paddr == CapAddr)) begin
      cap_nxt = pwdata[CapW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= MaxCapacity;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == CapAddr) begin
      prdata = {{(32-CapW){1'b0}}, cap_r};
    end
  end

  assign capacity = cap_r;

endmodule

### rtl/wrld_decode.sv
// Decoder state machine: phase, words left and write position, updated once
// per accepted word, with the result it causes. Depends on wrld_pkg.
module wrld_decode import wrld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [WordW-1:0]  word,
  input  logic              eos,
  input  logic [CapW-1:0]   capacity,
  output logic              res_valid,
  output result_t           res,
  output dec_status_t       dstat
);

  phase_t          phase_r, phase_nxt;
  logic [CntW-1:0] left_r, left_nxt;
  logic [CapW-1:0] pos_r, pos_nxt;

  logic [CapW-1:0] cap;
  logic [CntW-1:0] cnt;
  logic [CapW:0]   end_pos;
  logic            too_big;
  logic [CntW-1:0] left_dec;

  always_comb begin
    cap      = (capacity > MaxCapacity) ? MaxCapacity : capacity;
    cnt      = word[CntW-1:0];
    end_pos  = {1'b0, pos_r} + {{(CapW+1-CntW){1'b0}}, cnt};
    too_big  = end_pos > {1'b0, cap};
    left_dec = left_r - {{(CntW-1){1'b0}}, 1'b1};
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    if (accept) begin
      case (phase_r)
        PH_VERSION: begin
          if (word != VersionZero || eos) begin
            phase_nxt = eos ? PH_VERSION : PH_DISCARD;
            left_nxt  = '0;
          end else begin
            pos_nxt   = '0;
            left_nxt  = '0;
            phase_nxt = PH_DESC;
          end
        end
        PH_DESC: begin
          if (word == EndMarker || eos) begin
            phase_nxt = PH_VERSION;
            left_nxt  = '0;
          end else if (too_big) begin
            phase_nxt = PH_DISCARD;
            left_nxt  = '0;
          end else begin
            left_nxt = cnt;
            if (word[WordW-1]) begin
              phase_nxt = PH_RUNVAL;
            end else begin
              phase_nxt = (cnt != '0) ? PH_LITERAL : PH_DESC;
            end
          end
        end
        PH_RUNVAL: begin
          left_nxt = '0;
          if (eos) begin
            phase_nxt = PH_VERSION;
          end else begin
            pos_nxt   = pos_r + {{(CapW-CntW){1'b0}}, left_r};
            phase_nxt = PH_DESC;
          end
        end
        PH_LITERAL: begin
          if (eos) begin
            phase_nxt = PH_VERSION;
            left_nxt  = '0;
          end else begin
            pos_nxt  = pos_r + {{(CapW-1){1'b0}}, 1'b1};
            left_nxt = left_dec;
            if (left_dec == '0) begin
              phase_nxt = PH_DESC;
            end
          end
        end
        PH_DISCARD: begin
          if (eos) begin
            phase_nxt = PH_VERSION;
            left_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = PH_VERSION;
          left_nxt  = '0;
        end
      endcase
    end
  end

  // Result of the current word.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (accept) begin
      case (phase_r)
        PH_VERSION: begin
          if (word != VersionZero || eos) begin
            res_valid  = 1'b1;
            res.kind   = 1'b1;
            res.status = ST_CORRUPT;
          end
        end
        PH_DESC: begin
          if (word == EndMarker) begin
            res_valid  = 1'b1;
            res.kind   = 1'b1;
            res.status = ST_OK;
          end else if (eos) begin
            res_valid  = 1'b1;
            res.kind   = 1'b1;
            res.status = ST_CORRUPT;
          end else if (too_big) begin
            res_valid  = 1'b1;
            res.kind   = 1'b1;
            res.status = ST_TOO_SMALL;
          end
        end
        PH_RUNVAL: begin
          if (eos) begin
            res_valid  = 1'b1;
            res.kind   = 1'b1;
            res.status = ST_CORRUPT;
          end else if (left_r != '0) begin
            res_valid        = 1'b1;
            res.write_offset = pos_r[OffW-1:0];
            res.write_value  = word;
            res.repeat_count = left_r;
          end
        end
        PH_LITERAL: begin
          res_valid = 1'b1;
          if (eos) begin
            res.kind   = 1'b1;
            res.status = ST_CORRUPT;
          end else begin
            res.write_offset = pos_r[OffW-1:0];
            res.write_value  = word;
            res.repeat_count = {{(CntW-1){1'b0}}, 1'b1};
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_VERSION;
      left_r  <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign dstat.phase          = phase_r;
  assign dstat.write_position = pos_r;

endmodule

### rtl/wrld_outbuf.sv
// Result register with one skid entry, so a stalled receiver does not stop
// the input side until the skid entry fills. Depends on wrld_pkg.
module wrld_outbuf import wrld_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data,
  output logic    skid_full
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = push_data;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign skid_full = skid_valid_r;

endmodule
